### hw/rtl/tds_pkg.sv
// Shared types and constants for the tick deadline scheduler.
package tds_pkg;

   localparam int unsigned CntrW   = 64;
   localparam int unsigned PeriodW = 32;
   localparam int unsigned CountW  = 32;
   localparam int unsigned CmdW    = 3;

   localparam logic [PeriodW-1:0] PERIOD_RESET = 32'd19200;

   typedef enum logic [CmdW-1:0] {
      CMD_ARM    = 3'd0,
      CMD_TICK   = 3'd1,
      CMD_PARK   = 3'd2,
      CMD_UNPARK = 3'd3,
      CMD_STOP   = 3'd4
   } tds_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEXT,
      ST_EXEC,
      ST_DIV,
      ST_OUT
   } tds_state_type;

   // Request to the divider.
   typedef struct packed {
      logic               start;
      logic [CntrW-1:0]   dividend;
      logic [PeriodW-1:0] divisor;
   } tds_div_req_type;

   // Status back from the divider.
   typedef struct packed {
      logic               busy;
      logic               done;
      logic [CountW-1:0]  quotient;
   } tds_div_rsp_type;

endpackage

### hw/rtl/tds_div.sv
// Bit-serial restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module tds_div (
   input  logic                     clock,
   input  logic                     reset,
   input  tds_pkg::tds_div_req_type div_req,
   output tds_pkg::tds_div_rsp_type div_rsp
);
   import tds_pkg::*;

   localparam int unsigned StepW = $clog2(CntrW);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [StepW-1:0]   step_ff, step_in;
   logic [CntrW-1:0]   dvd_ff, dvd_in;     // dividend shifts out, quotient shifts in
   logic [PeriodW-1:0] rem_ff, rem_in;
   logic [PeriodW-1:0] dsr_ff, dsr_in;

   logic [PeriodW:0]   trial;
   logic               fits;

   // Zero divisor always fits, so the quotient comes out all ones.
   assign trial = {rem_ff, dvd_ff[CntrW-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? PeriodW'(trial - {1'b0, dsr_ff}) : trial[PeriodW-1:0];
         dvd_in  = {dvd_ff[CntrW-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == StepW'(CntrW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff[CountW-1:0];

endmodule

### hw/rtl/tick_deadline_scheduler.sv
// Tick deadline scheduler top level: command sequencer, state and result register.
//
// Keeps an absolute 64-bit comparator deadline that advances by one tick period per
// serviced tick, plus park/unpark bookkeeping for suspend windows. Each request
// transaction returns exactly one response transaction. Arm, tick, park, stop and
// unknown commands pass through ST_NEXT, ST_EXEC and ST_OUT after acceptance before
// the response is offered; unpark also waits in ST_DIV on the bit-serial divider,
// which produces one quotient bit per cycle. A new request is taken once the previous
// command has left the sequencer, even while its response still waits in the output register.
// tick_period is written through csr_we/csr_wdata and should only change while idle.
module tick_deadline_scheduler (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [31:0]   csr_wdata,     // tick_period
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,     // [63:0] now, [127:64] park_deadline
   input  logic [2:0]    req_tuser,     // [2:0] command
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata      // [63:0] compare_value, [64] timer_enable,
                                        // [65] is_parked, [97:66] missed_ticks, rest 0
);
   import tds_pkg::*;

   localparam int unsigned RspW = 104;
   localparam int unsigned RspUsed = CntrW + 2 + CountW;

   tds_state_type      state_ff, state_in;

   logic [PeriodW-1:0] period_ff, period_in;
   tds_cmd_type        cmd_ff, cmd_in;
   logic [CntrW-1:0]   now_ff, now_in;
   logic [CntrW-1:0]   req_dl_ff, req_dl_in;
   logic [CntrW-1:0]   next_ff, next_in;

   logic [CntrW-1:0]   deadline_ff, deadline_in;
   logic               parked_ff, parked_in;
   logic [CntrW-1:0]   mark_ff, mark_in;
   logic [CountW-1:0]  svc_ff, svc_in;
   logic               enabled_ff, enabled_in;
   logic [CountW-1:0]  missed_ff, missed_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RspW-1:0]    rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               out_load;
   logic               div_start;
   logic [CntrW-1:0]   adv_sum;

   tds_div_req_type    div_req;
   tds_div_rsp_type    div_rsp;

   tds_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_NEXT;
         ST_NEXT: state_in = ST_EXEC;
         ST_EXEC: state_in = (cmd_ff == CMD_UNPARK) ? ST_DIV : ST_OUT;
         ST_DIV:  if (div_rsp.done) state_in = ST_OUT;
         ST_OUT:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      out_load   = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_EXEC: div_start = (cmd_ff == CMD_UNPARK);
         ST_OUT:  out_load = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign accept  = req_tvalid && req_tready;
   // start, dividend, divisor
   assign div_req = {div_start, now_ff - mark_ff, period_ff};
   assign adv_sum = deadline_ff + CntrW'(period_ff);

   always_comb begin
      period_in   = csr_we ? csr_wdata : period_ff;
      cmd_in      = accept ? tds_cmd_type'(req_tuser) : cmd_ff;
      now_in      = accept ? req_tdata[CntrW-1:0] : now_ff;
      req_dl_in   = accept ? req_tdata[2*CntrW-1:CntrW] : req_dl_ff;
      next_in     = (state_ff == ST_NEXT) ? now_ff + CntrW'(period_ff) : next_ff;
      deadline_in = deadline_ff;
      parked_in   = parked_ff;
      mark_in     = mark_ff;
      svc_in      = svc_ff;
      enabled_in  = enabled_ff;
      missed_in   = missed_ff;
      if (state_ff == ST_EXEC) begin
         missed_in = '0;
         case (cmd_ff)
            CMD_ARM: begin
               parked_in   = 1'b0;
               deadline_in = next_ff;
               enabled_in  = 1'b1;
            end
            CMD_TICK: begin
               if (parked_ff) begin
                  svc_in      = svc_ff + 1'b1;
                  deadline_in = next_ff;
               end else begin
                  // fell behind: resync instead of firing a burst of late ticks
                  deadline_in = (adv_sum <= now_ff) ? next_ff : adv_sum;
               end
            end
            CMD_PARK: begin
               deadline_in = (req_dl_ff < next_ff) ? next_ff : req_dl_ff;
               mark_in     = now_ff;
               svc_in      = '0;
               parked_in   = 1'b1;
            end
            CMD_UNPARK: begin
               parked_in   = 1'b0;
               deadline_in = next_ff;
            end
            CMD_STOP: enabled_in = 1'b0;
            default: ;
         endcase
      end else if (state_ff == ST_DIV && div_rsp.done) begin
         missed_in = (div_rsp.quotient > svc_ff) ? div_rsp.quotient - svc_ff : '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(RspW-RspUsed)'(0), missed_ff, parked_ff, enabled_ff, deadline_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_RESET;
         deadline_ff  <= '0;
         parked_ff    <= 1'b0;
         mark_ff      <= '0;
         svc_ff       <= '0;
         enabled_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         deadline_ff  <= deadline_in;
         parked_ff    <= parked_in;
         mark_ff      <= mark_in;
         svc_ff       <= svc_in;
         enabled_ff   <= enabled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      now_ff      <= now_in;
      req_dl_ff   <= req_dl_in;
      next_ff     <= next_in;
      missed_ff   <= missed_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_div_only_unpark: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cmd_ff == CMD_UNPARK)
      else $error("divider wait entered for a non-unpark command");

   a_div_starts: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> div_rsp.busy)
      else $error("divider did not start");

   a_div_done_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_rsp.done) |=> state_ff == ST_OUT)
      else $error("quotient dropped by sequencer");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("response not presented after load");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !out_load)
      else $error("pending response overwritten");

endmodule

### tb/tick_deadline_scheduler_tb.sv
// Self-checking testbench for the tick deadline scheduler: directed, random and back-pressure traffic.
`timescale 1ns / 1ps

module tick_deadline_scheduler_tb;
   import tds_pkg::*;

   // Command codes the block must ignore.
   localparam logic [CmdW-1:0] CMD_RSVD5 = 3'd5;
   localparam logic [CmdW-1:0] CMD_RSVD6 = 3'd6;
   localparam logic [CmdW-1:0] CMD_RSVD7 = 3'd7;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned TAIL_CYCLES = 80;

   typedef struct {
      logic [CntrW-1:0]  compare_value;
      logic              timer_enable;
      logic              is_parked;
      logic [CountW-1:0] missed_ticks;
   } sched_result_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           csr_we = 1'b0;
   logic [31:0]    csr_wdata = '0;
   logic           req_tvalid = 1'b0;
   logic           req_tready;
   logic [127:0]   req_tdata = '0;    // [63:0] now, [127:64] park_deadline
   logic [2:0]     req_tuser = '0;    // [2:0] command
   logic           rsp_tvalid;
   logic           rsp_tready = 1'b0;
   logic [103:0]   rsp_tdata;         // [63:0] compare_value, [64] timer_enable,
                                      // [65] is_parked, [97:66] missed_ticks

   // Predicted scheduler state
   logic [PeriodW-1:0] exp_period = PERIOD_RESET;
   logic [CntrW-1:0]   exp_deadline = '0;
   logic               exp_parked = 1'b0;
   logic [CntrW-1:0]   exp_mark = '0;
   logic [CountW-1:0]  exp_serviced = '0;
   logic               exp_enabled = 1'b0;

   sched_result_type pending_results[$];
   int unsigned   fail_count = 0;
   int unsigned   result_count = 0;
   int unsigned   items_accepted = 0;
   int unsigned   cycle_count = 0;
   logic [63:0]   sys_count = '0;
   bit            send_idles = 1'b1;
   bit            recv_idles = 1'b1;
   int unsigned   hold_request = 0;
   int unsigned   hold_left = 0;

   tick_deadline_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tick_deadline_scheduler_tb: FAIL");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Applies one command to the predicted state and returns the response it should produce.
   function automatic sched_result_type advance_schedule(logic [CmdW-1:0] cmd,
                                                         logic [63:0] now,
                                                         logic [63:0] wake);
      logic [63:0]       next_dl;
      logic [63:0]       quot;
      logic [CountW-1:0] elapsed;
      sched_result_type  res;
      next_dl = now + 64'(exp_period);
      res.missed_ticks = '0;
      case (cmd)
         CMD_ARM: begin
            exp_parked = 1'b0;
            exp_deadline = next_dl;
            exp_enabled = 1'b1;
         end
         CMD_TICK: begin
            if (exp_parked) begin
               exp_serviced = exp_serviced + 1'b1;
               exp_deadline = next_dl;
            end else begin
               exp_deadline = exp_deadline + 64'(exp_period);
               if (exp_deadline <= now)
                  exp_deadline = next_dl;
            end
         end
         CMD_PARK: begin
            if (wake < next_dl)
               wake = next_dl;
            exp_mark = now;
            exp_serviced = '0;
            exp_parked = 1'b1;
            exp_deadline = wake;
         end
         CMD_UNPARK: begin
            // divide by zero saturates the quotient, as a restoring divider does
            if (exp_period == '0) begin
               elapsed = '1;
            end else begin
               quot = (now - exp_mark) / 64'(exp_period);
               elapsed = quot[CountW-1:0];
            end
            exp_parked = 1'b0;
            if (elapsed > exp_serviced)
               res.missed_ticks = elapsed - exp_serviced;
            exp_deadline = next_dl;
         end
         CMD_STOP: exp_enabled = 1'b0;
         default: ;
      endcase
      res.compare_value = exp_deadline;
      res.timer_enable = exp_enabled;
      res.is_parked = exp_parked;
      return res;
   endfunction

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("error %0d at %0t: %s", fail_count, $time, msg);
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got)
         note_failure($sformatf("response %0d %s: expected %h, got %h",
                                result_count, name, want, got));
   endfunction

   // Response monitor
   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            note_failure($sformatf("response with no transaction outstanding: %h", rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            check_field("compare_value", want.compare_value, rsp_tdata[63:0]);
            check_field("timer_enable", 64'(want.timer_enable), 64'(rsp_tdata[64]));
            check_field("is_parked", 64'(want.is_parked), 64'(rsp_tdata[65]));
            check_field("missed_ticks", 64'(want.missed_ticks), 64'(rsp_tdata[97:66]));
            check_field("padding", '0, 64'(rsp_tdata[103:98]));
         end
         result_count++;
      end
   end

   // Response-side ready: random stalls, occasional long holds, forced holds on request
   always @(posedge clock) begin
      int unsigned roll;
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!recv_idles) begin
         rsp_tready <= 1'b1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 2)
            hold_left = $urandom_range(8, 40);
         rsp_tready <= (roll >= 25);
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!send_idles)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_command(input logic [CmdW-1:0] cmd, input logic [63:0] now,
                               input logic [63:0] wake);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {wake, now};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(advance_schedule(cmd, now, wake));
      items_accepted++;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] value);
      drain_results();
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      exp_period = value;
   endtask

   function automatic logic [63:0] tick_spacing();
      if ($urandom_range(0, 9) == 0)
         return 64'($urandom_range(0, exp_period / 2));    // early tick
      if ($urandom_range(0, 9) == 0)
         return 64'(exp_period) * $urandom_range(2, 40);   // late, forces resync
      return 64'(exp_period) + $urandom_range(0, exp_period / 8);
   endfunction

   // One armed session: on-time and late ticks, park windows, stops, plus some noise
   task automatic run_session();
      int unsigned n_events;
      int unsigned pick;
      logic [63:0] wake;
      send_idles = ($urandom_range(0, 3) != 0);
      recv_idles = ($urandom_range(0, 3) != 0);
      n_events = $urandom_range(8, 30);
      sys_count += $urandom_range(0, 1000);
      send_command(CMD_ARM, sys_count, rand64());
      repeat (n_events) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            sys_count += tick_spacing();
            send_command(CMD_TICK, sys_count, rand64());
         end else if (pick < 67) begin
            // short wake requests get clamped to one period out
            if ($urandom_range(0, 3) == 0)
               wake = sys_count + $urandom_range(0, exp_period);
            else
               wake = sys_count + 64'(exp_period) * $urandom_range(1, 5000);
            send_command(CMD_PARK, sys_count, wake);
            repeat ($urandom_range(0, 6)) begin
               sys_count += 64'(exp_period) * $urandom_range(0, 3)
                            + $urandom_range(0, exp_period);
               send_command(CMD_TICK, sys_count, rand64());
            end
            sys_count += 64'(exp_period) * $urandom_range(0, 300) + $urandom_range(0, exp_period);
            send_command(CMD_UNPARK, sys_count, rand64());
         end else if (pick < 73) begin
            sys_count += tick_spacing();
            send_command(CMD_STOP, sys_count, rand64());
            if ($urandom_range(0, 1) == 0) begin
               sys_count += tick_spacing();
               send_command(CMD_ARM, sys_count, rand64());
            end
         end else if (pick < 78) begin
            sys_count += tick_spacing();
            send_command(CMD_UNPARK, sys_count, rand64());
         end else begin
            send_command(3'($urandom_range(CMD_ARM, CMD_RSVD7)), rand64(), rand64());
         end
      end
   endtask

   task automatic run_traffic(input int unsigned n_items);
      int unsigned start;
      start = items_accepted;
      if ($urandom_range(0, 3) == 0)
         sys_count = '1 - $urandom_range(0, 100000);      // wrap the counter early on
      else
         sys_count = rand64();
      while (items_accepted - start < n_items)
         run_session();
   endtask

   // Reset period throughout
   task automatic test_directed_commands();
      logic [63:0] p;
      logic [63:0] mark;
      p = 64'(exp_period);
      send_command(CMD_UNPARK, 64'd123_456_789, '0);     // unpark with no park yet
      send_command(CMD_TICK, '0, '0);                    // tick while disarmed
      send_command(CMD_ARM, '0, '1);
      send_command(CMD_TICK, p, '0);
      send_command(CMD_TICK, 64'd1, '0);
      send_command(CMD_TICK, 50 * p, '0);
      mark = 50 * p + 5;
      send_command(CMD_PARK, mark, '1);
      send_command(CMD_TICK, mark + p, '0);
      send_command(CMD_TICK, mark + 2 * p, '0);
      send_command(CMD_UNPARK, mark + 7 * p, '0);
      mark = 60 * p;
      send_command(CMD_PARK, mark, '0);
      repeat (3) send_command(CMD_TICK, mark + 1, rand64());
      send_command(CMD_UNPARK, mark + p, '0);           // more serviced than elapsed
      send_command(CMD_STOP, mark + 2 * p, '0);
      send_command(CMD_TICK, mark + 3 * p, '0);
      send_command(CMD_RSVD5, rand64(), rand64());
      send_command(CMD_RSVD6, rand64(), rand64());
      send_command(CMD_RSVD7, rand64(), rand64());
      send_command(CMD_ARM, '1, '0);
      send_command(CMD_PARK, '1 - 64'd10, 64'd5);
      send_command(CMD_UNPARK, 64'd3, '1);               // counter wrapped past the mark
      send_command(CMD_TICK, '1, '0);
   endtask

   task automatic test_period_extremes();
      configure(32'd1);
      run_traffic(80);
      configure('1);
      run_traffic(80);
      configure('0);
      run_traffic(60);
   endtask

   task automatic test_random_traffic();
      configure($urandom_range(1, 64));
      run_traffic(300);
      configure($urandom_range(65, 65535));
      run_traffic(400);
      configure($urandom);
      run_traffic(400);
      configure(PERIOD_RESET);
      run_traffic(300);
   endtask

   // Hold responses off long enough that the request side backs up
   task automatic test_output_backpressure();
      send_idles = 1'b0;
      hold_request = 400;
      sys_count += $urandom_range(0, 1000);
      send_command(CMD_ARM, sys_count, '0);
      repeat (12) begin
         sys_count += tick_spacing();
         send_command(CMD_TICK, sys_count, rand64());
      end
      send_command(CMD_PARK, sys_count, rand64());
      sys_count += 64'(exp_period) * $urandom_range(0, 50);
      send_command(CMD_UNPARK, sys_count, '0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_commands();
      test_period_extremes();
      test_random_traffic();
      test_output_backpressure();
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tick_deadline_scheduler_tb: PASS");
      else
         $display("tick_deadline_scheduler_tb: FAIL");
      $finish;
   end

endmodule
